[sv/sem_pkg.sv]
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types, constants and helpers for the sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

	localparam int unsigned MaxWidthDef  = 1024;
	localparam int unsigned MaxHeightDef = 4096;

	localparam int unsigned AddrW = 5;
	localparam logic [AddrW-1:0] RegWidth  = 5'h00;
	localparam logic [AddrW-1:0] RegHeight = 5'h04;
	localparam logic [AddrW-1:0] RegWRed   = 5'h08;
	localparam logic [AddrW-1:0] RegWGreen = 5'h0c;
	localparam logic [AddrW-1:0] RegWBlue  = 5'h10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_ROOT,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture pixel, start line-store read
		logic shift;     // update window, write line stores, step counters
		logic calc;      // compute sum of squares for selected result
		logic emit;      // place result in output register
		logic [1:0] sel; // which of the four possible results
		logic last;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [3:0] want; // which results this pixel causes
		logic       root_done;
	} dp_stat_t;

endpackage

[sv/sem_ram.sv]
// ----------------------------------------------------------------------------
// sem_ram
// Generic single-port write, single-port read ram with registered read.
// ----------------------------------------------------------------------------
module sem_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[sv/sem_ctrl.sv]
// ----------------------------------------------------------------------------
// sem_ctrl
// Sequencer: accepts a pixel, walks the results it causes, hands them out.
// ----------------------------------------------------------------------------
module sem_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  sem_pkg::dp_stat_t stat,
	output sem_pkg::dp_cmd_t  cmd
);
	import sem_pkg::*;

	state_t     state_q, state_d;
	logic [3:0] left_q, left_d;
	logic       ovalid_q, ovalid_d;
	logic [1:0] pick;
	logic [3:0] rest;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			left_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			left_q   <= left_d;
			ovalid_q <= ovalid_d;
		end
	end

	// lowest pending result first
	always_comb begin
		pick = 2'd0;
		priority if (left_q[0]) pick = 2'd0;
		else if (left_q[1]) pick = 2'd1;
		else if (left_q[2]) pick = 2'd2;
		else pick = 2'd3;
		rest = left_q & ~(4'b0001 << pick);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ovalid_q;

	always_comb begin
		state_d  = state_q;
		left_d   = left_q;
		ovalid_d = ovalid_q;
		cmd      = '0;
		cmd.sel  = pick;
		cmd.last = (rest == 4'd0);
		if (ovalid_q && m_tready) ovalid_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.shift   = 1'b1;
				left_d      = stat.want;
				state_d     = (stat.want == 4'd0) ? ST_IDLE : ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_ROOT;
			end
			ST_ROOT: begin
				if (stat.root_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!ovalid_q || m_tready) begin
					cmd.emit = 1'b1;
					ovalid_d = 1'b1;
					left_d   = rest;
					state_d  = (rest == 4'd0) ? ST_IDLE : ST_CALC;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

[sv/sem_dp.sv]
// ----------------------------------------------------------------------------
// sem_dp
// Datapath: luma, line stores, 3x3 window, sobel sums and bit-serial root.
// ----------------------------------------------------------------------------
module sem_dp #(
	parameter int unsigned MaxWidth  = sem_pkg::MaxWidthDef,
	parameter int unsigned MaxHeight = sem_pkg::MaxHeightDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sem_pkg::dp_cmd_t  cmd,
	output sem_pkg::dp_stat_t stat,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  logic [7:0]        opacity,
	input  logic              geom_restart,
	input  logic [10:0]       image_width,
	input  logic [12:0]       image_height,
	input  logic [8:0]        weight_red,
	input  logic [8:0]        weight_green,
	input  logic [8:0]        weight_blue,
	output logic [7:0]        magnitude,
	output logic [7:0]        opacity_out,
	output logic [9:0]        column,
	output logic [11:0]       line,
	output logic              last_of_run
);
	import sem_pkg::*;

	localparam int unsigned XW = $clog2(MaxWidth);
	localparam int unsigned YW = $clog2(MaxHeight) > 0 ? $clog2(MaxHeight) : 1;

	logic [XW:0] wclamp;
	logic [YW:0] hclamp;
	logic [XW-1:0] wl;
	logic [YW-1:0] hl;
	logic [XW-1:0] col_q, x;
	logic [YW-1:0] row_q, y;

	always_comb begin
		if (image_width == 11'd0) wclamp = (XW+1)'(1);
		else if ({{(XW+12){1'b0}}, image_width} > (XW+12+11)'(MaxWidth))
			wclamp = (XW+1)'(MaxWidth);
		else wclamp = (XW+1)'(image_width);
		if (image_height == 13'd0) hclamp = (YW+1)'(1);
		else if ({{(YW+14){1'b0}}, image_height} > (YW+14+13)'(MaxHeight))
			hclamp = (YW+1)'(MaxHeight);
		else hclamp = (YW+1)'(image_height);
		wl = XW'(wclamp - 1'b1);
		hl = YW'(hclamp - 1'b1);
		x  = (col_q > wl) ? wl : col_q;
		y  = (row_q > hl) ? hl : row_q;
	end

	// luma: three narrow products and a sum
	logic [7:0]  a_s1;
	logic [18:0] lsum_s1;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_s1    <= opacity;
			lsum_s1 <= 19'(weight_red * red) + 19'(weight_green * green)
				+ 19'(weight_blue * blue);
		end
	end
	logic [7:0] luma;
	assign luma = (lsum_s1[18:16] != 3'd0) ? 8'd255 : lsum_s1[15:8];

	logic [7:0] old_rd, new_rd, alp_rd;
	sem_ram #(.Width(8), .Depth(MaxWidth)) u_old (.clk(clk), .we(cmd.shift),
		.waddr(x), .wdata(new_rd), .raddr(x), .rdata(old_rd));
	sem_ram #(.Width(8), .Depth(MaxWidth)) u_new (.clk(clk), .we(cmd.shift),
		.waddr(x), .wdata(luma), .raddr(x), .rdata(new_rd));
	sem_ram #(.Width(8), .Depth(MaxWidth)) u_alp (.clk(clk), .we(cmd.shift),
		.waddr(x), .wdata(a_s1), .raddr(x), .rdata(alp_rd));

	logic [7:0] win_q [3][3];
	logic [7:0] aw_q [2][2];
	logic [XW-1:0] px_q;
	logic [YW-1:0] py_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
			for (int i = 0; i < 2; i++)
				for (int j = 0; j < 2; j++) aw_q[i][j] <= '0;
			col_q <= '0;
			row_q <= '0;
			px_q  <= '0;
			py_q  <= '0;
		end else if (geom_restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.shift) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= old_rd;
			win_q[1][2] <= new_rd;
			win_q[2][2] <= luma;
			aw_q[0][0] <= aw_q[0][1];
			aw_q[0][1] <= alp_rd;
			aw_q[1][0] <= aw_q[1][1];
			aw_q[1][1] <= a_s1;
			px_q <= x;
			py_q <= y;
			if (x == wl) begin
				col_q <= '0;
				row_q <= (y == hl) ? '0 : YW'(y + 1'b1);
			end else begin
				col_q <= XW'(x + 1'b1);
			end
		end
	end

	assign stat.want[0] = (y != '0) && (x != '0);
	assign stat.want[1] = (y != '0) && (x == wl);
	assign stat.want[2] = (y == hl) && (x != '0);
	assign stat.want[3] = (y == hl) && (x == wl);

	// selected result geometry
	logic [1:0] ti, mi;
	logic [1:0] cc, li, ri;
	logic [XW-1:0] oc;
	logic [YW-1:0] orow;
	logic [7:0] oa;
	always_comb begin
		if (!cmd.sel[1]) begin
			ti = (py_q == YW'(1)) ? 2'd1 : 2'd0;
			mi = 2'd1;
			orow = YW'(py_q - 1'b1);
		end else begin
			ti = (py_q == '0) ? 2'd2 : 2'd1;
			mi = 2'd2;
			orow = py_q;
		end
		if (!cmd.sel[0]) begin
			cc = 2'd1;
			oc = XW'(px_q - 1'b1);
		end else begin
			cc = 2'd2;
			oc = px_q;
		end
		oa = aw_q[cmd.sel[1]][cmd.sel[0]];
		li = (oc == '0) ? cc : 2'(cc - 1'b1);
		ri = (oc == wl) ? cc : 2'(cc + 1'b1);
		if (ri > 2'd2) ri = 2'd2;
	end

	logic signed [10:0] gx, gy;
	logic signed [21:0] gxx, gyy;
	always_comb begin
		gx = 11'(signed'({3'b0, win_q[ti][ri]})) - 11'(signed'({3'b0, win_q[ti][li]}))
			+ 11'(signed'({2'b0, win_q[mi][ri], 1'b0}))
			- 11'(signed'({2'b0, win_q[mi][li], 1'b0}))
			+ 11'(signed'({3'b0, win_q[2][ri]})) - 11'(signed'({3'b0, win_q[2][li]}));
		gy = 11'(signed'({3'b0, win_q[2][li]})) + 11'(signed'({2'b0, win_q[2][cc], 1'b0}))
			+ 11'(signed'({3'b0, win_q[2][ri]})) - 11'(signed'({3'b0, win_q[ti][li]}))
			- 11'(signed'({2'b0, win_q[ti][cc], 1'b0}))
			- 11'(signed'({3'b0, win_q[ti][ri]}));
		gxx = gx * gx;
		gyy = gy * gy;
	end

	// sum of squares, then one root bit per cycle
	logic [20:0] sq_q;
	logic [7:0]  m_q;
	logic [3:0]  bit_q;
	logic [7:0]  oa_q;
	logic [XW-1:0] oc_q;
	logic [YW-1:0] or_q;
	logic [7:0]  t;
	logic [15:0] tt;
	logic        busy_q;
	assign t  = m_q | (8'd1 << bit_q[2:0]);
	assign tt = t * t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q  <= '0;
		end else if (cmd.calc) begin
			busy_q <= 1'b1;
			bit_q  <= 4'd7;
		end else if (busy_q) begin
			if (bit_q == 4'd0) busy_q <= 1'b0;
			else bit_q <= bit_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			sq_q <= gxx[20:0] + gyy[20:0];
			m_q  <= '0;
			oa_q <= oa;
			oc_q <= oc;
			or_q <= orow;
		end else if (busy_q) begin
			if ({5'd0, tt} <= sq_q) m_q <= t;
		end
	end
	assign stat.root_done = !busy_q;

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			magnitude   <= (sq_q >= 21'd65536) ? 8'd255 : m_q;
			opacity_out <= oa_q;
			column      <= 10'(oc_q);
			line        <= 12'(or_q);
			last_of_run <= cmd.last;
		end
	end
endmodule

[sv/sobel_edge_magnitude.sv]
// A pixel is first read from the line stores; each result it causes is then worked out
// (window sums, then an 8-step bit-serial square root) before it shows on m_*.
// A new pixel is taken only once every result of the previous one is in the output register.
// Reset (arst_n low): registers return to 640x480 and weights 77/150/29,
// counters and window clear; line stores are not cleared.
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Top level: apb registers, sequencer and sobel datapath.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
	parameter int unsigned MaxWidth  = sem_pkg::MaxWidthDef,
	parameter int unsigned MaxHeight = sem_pkg::MaxHeightDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [sem_pkg::AddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // red, green, blue, opacity
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // magnitude, opacity_out, column, line, 2'b0
	output logic        m_tlast   // last_of_run
);
	import sem_pkg::*;

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [8:0]  wr_q, wg_q, wb_q;
	logic        wen, restart;

	assign pready = 1'b1;
	assign wen    = psel && penable && pwrite;
	assign restart = wen && (paddr == RegWidth || paddr == RegHeight);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 13'd480;
			wr_q     <= 9'd77;
			wg_q     <= 9'd150;
			wb_q     <= 9'd29;
		end else if (wen) begin
			unique case (paddr)
				RegWidth:  width_q  <= pwdata[10:0];
				RegHeight: height_q <= pwdata[12:0];
				RegWRed:   wr_q     <= pwdata[8:0];
				RegWGreen: wg_q     <= pwdata[8:0];
				RegWBlue:  wb_q     <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			RegWidth:  prdata = {21'd0, width_q};
			RegHeight: prdata = {19'd0, height_q};
			RegWRed:   prdata = {23'd0, wr_q};
			RegWGreen: prdata = {23'd0, wg_q};
			RegWBlue:  prdata = {23'd0, wb_q};
			default:   prdata = 32'd0;
		endcase
	end

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic [7:0] mag, oa;
	logic [9:0] col;
	logic [11:0] ln;

	sem_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .stat(stat), .cmd(cmd)
	);

	sem_dp #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.red(s_tdata[7:0]), .green(s_tdata[15:8]), .blue(s_tdata[23:16]),
		.opacity(s_tdata[31:24]), .geom_restart(restart),
		.image_width(width_q), .image_height(height_q),
		.weight_red(wr_q), .weight_green(wg_q), .weight_blue(wb_q),
		.magnitude(mag), .opacity_out(oa), .column(col), .line(ln),
		.last_of_run(m_tlast)
	);

	assign m_tdata = {2'b00, ln, col, oa, mag};
endmodule

[sv/sem_checker.sv]
// ----------------------------------------------------------------------------
// sem_checker
// Port-level checks for the sobel edge magnitude block.
// ----------------------------------------------------------------------------
module sem_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        pready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:38] == 2'b00)
		else $error("pad bits set");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second pixel taken back to back");
	a_rdy: assert property (@(posedge clk) pready)
		else $error("pready low");
endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);

[test/tb_sobel_edge_magnitude.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude
// Self-checking bench: drives pixel frames at several geometries and luma
// weights, predicts every edge result in the bench and compares each m_* beat.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude;
	import sem_pkg::*;

	localparam int unsigned MaxW = 1024;
	localparam int unsigned MaxH = 4096;
	localparam int unsigned IdleLimit = 20000;

	typedef struct packed {
		logic [7:0]  magnitude;
		logic [7:0]  opacity_out;
		logic [9:0]  column;
		logic [11:0] line;
		logic        last_of_run;
	} edge_res_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [AddrW-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic s_tvalid, s_tready;
	logic [31:0] s_tdata;
	logic m_tvalid, m_tready;
	logic [39:0] m_tdata;
	logic m_tlast;

	sobel_edge_magnitude dut (.*);

	// predictor state
	int unsigned cfg_w, cfg_h, wt_r, wt_g, wt_b;
	logic [7:0] older_row [MaxW];
	logic [7:0] newer_row [MaxW];
	logic [7:0] alpha_line [MaxW];
	logic [7:0] win [3][3];
	logic [7:0] awin [2][2];
	int unsigned col_pos, row_pos;

	edge_res_t edge_queue[$];
	int unsigned mismatches, results_seen, pixels_sent;
	int unsigned send_idle_pct, recv_idle_pct;
	bit hold_recv;
	int unsigned idle_cycles;
	bit done_flag;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned eff_w();
		if (cfg_w < 1) return 1;
		if (cfg_w > MaxW) return MaxW;
		return cfg_w;
	endfunction

	function automatic int unsigned eff_h();
		if (cfg_h < 1) return 1;
		if (cfg_h > MaxH) return MaxH;
		return cfg_h;
	endfunction

	function automatic logic [7:0] root_sat(int unsigned s);
		int unsigned m, t;
		m = 0;
		if (s >= 65536) return 8'hff;
		for (int b = 7; b >= 0; b--) begin
			t = m | (1 << b);
			if (t * t <= s) m = t;
		end
		return m[7:0];
	endfunction

	function automatic logic [7:0] edge_mag(int t, int m, int b, int cc,
			int unsigned c, int unsigned w);
		int l, r, gx, gy;
		l = (c == 0) ? cc : cc - 1;
		r = (c == w - 1) ? cc : cc + 1;
		if (r > 2) r = 2;
		gx = (int'(win[t][r]) - int'(win[t][l])) + 2 * (int'(win[m][r]) - int'(win[m][l]))
			+ (int'(win[b][r]) - int'(win[b][l]));
		gy = (int'(win[b][l]) + 2 * int'(win[b][cc]) + int'(win[b][r]))
			- (int'(win[t][l]) + 2 * int'(win[t][cc]) + int'(win[t][r]));
		return root_sat(gx * gx + gy * gy);
	endfunction

	task automatic predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] bl,
			logic [7:0] a);
		int unsigned w, h, x, y, luma, t;
		edge_res_t res [$];
		edge_res_t e;
		w = eff_w();
		h = eff_h();
		x = col_pos;
		y = row_pos;
		luma = (wt_r * r + wt_g * g + wt_b * bl) >> 8;
		if (luma > 255) luma = 255;
		if (x >= w) x = w - 1;
		if (y >= h) y = h - 1;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = older_row[x];
		win[1][2] = newer_row[x];
		win[2][2] = luma[7:0];
		older_row[x] = newer_row[x];
		newer_row[x] = luma[7:0];
		awin[0][0] = awin[0][1];
		awin[0][1] = alpha_line[x];
		awin[1][0] = awin[1][1];
		awin[1][1] = a;
		alpha_line[x] = a;
		if (y >= 1) begin
			t = (y == 1) ? 1 : 0;
			if (x >= 1) begin
				e = '{edge_mag(t, 1, 2, 1, x - 1, w), awin[0][0], 10'(x - 1), 12'(y - 1), 1'b0};
				res.push_back(e);
			end
			if (x == w - 1) begin
				e = '{edge_mag(t, 1, 2, 2, x, w), awin[0][1], 10'(x), 12'(y - 1), 1'b0};
				res.push_back(e);
			end
		end
		if (y == h - 1) begin
			t = (y == 0) ? 2 : 1;
			if (x >= 1) begin
				e = '{edge_mag(t, 2, 2, 1, x - 1, w), awin[1][0], 10'(x - 1), 12'(y), 1'b0};
				res.push_back(e);
			end
			if (x == w - 1) begin
				e = '{edge_mag(t, 2, 2, 2, x, w), awin[1][1], 10'(x), 12'(y), 1'b0};
				res.push_back(e);
			end
		end
		if (res.size() > 0) res[res.size() - 1].last_of_run = 1'b1;
		foreach (res[i]) edge_queue.push_back(res[i]);
		x++;
		if (x >= w) begin
			x = 0;
			y++;
			if (y >= h) y = 0;
		end
		col_pos = x;
		row_pos = y;
	endtask

	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] bl,
			logic [7:0] a);
		while (($urandom % 100) < send_idle_pct) @(posedge clk);
		predict_pixel(r, g, bl, a);
		s_tvalid <= 1'b1;
		s_tdata <= {a, bl, g, r};
		do @(posedge clk); while (!s_tready);
		s_tvalid <= 1'b0;
		pixels_sent++;
		// the block is busy reading the line stores after each beat
		@(posedge clk);
	endtask

	task automatic send_random_pixel();
		send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic reg_write(logic [AddrW-1:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (addr)
			RegWidth: begin cfg_w = data & 32'h7ff; col_pos = 0; row_pos = 0; end
			RegHeight: begin cfg_h = data & 32'h1fff; col_pos = 0; row_pos = 0; end
			RegWRed: wt_r = data & 32'h1ff;
			RegWGreen: wt_g = data & 32'h1ff;
			RegWBlue: wt_b = data & 32'h1ff;
			default: ;
		endcase
	endtask

	// wait for every result, then for a pixel that causes none to finish
	task automatic drain();
		while (edge_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_frame(int unsigned w, int unsigned h);
		drain();
		reg_write(RegWidth, w);
		reg_write(RegHeight, h);
	endtask

	task automatic set_weights(int unsigned r, int unsigned g, int unsigned b);
		drain();
		reg_write(RegWRed, r);
		reg_write(RegWGreen, g);
		reg_write(RegWBlue, b);
	endtask

	task automatic send_frame();
		int unsigned n;
		n = eff_w() * eff_h();
		for (int unsigned i = 0; i < n; i++) send_random_pixel();
	endtask

	// extremes: black/white, saturated weights, single row, single column
	task automatic test_directed();
		set_frame(4, 3);
		set_weights(256, 256, 256);
		send_pixel(8'hff, 8'hff, 8'hff, 8'hff);
		send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
		send_pixel(8'hff, 8'h00, 8'hff, 8'h55);
		send_pixel(8'h00, 8'hff, 8'h00, 8'haa);
		for (int i = 0; i < 4; i++) send_pixel(8'h00, 8'h00, 8'h00, 8'hff);
		for (int i = 0; i < 4; i++) send_pixel(8'hff, 8'hff, 8'hff, 8'h00);
		set_weights(0, 0, 0);
		set_frame(1, 1);
		send_pixel(8'hff, 8'hff, 8'hff, 8'h81);
		set_frame(5, 1);
		set_weights(77, 150, 29);
		for (int i = 0; i < 5; i++)
			send_pixel((i & 1) ? 8'hff : 8'h00, 8'h80, 8'h7f, 8'(i));
		set_frame(1, 3);
		for (int i = 0; i < 3; i++) send_random_pixel();
		// out-of-range geometry is clamped
		set_frame(0, 0);
		send_random_pixel();
	endtask

	// geometry write mid-frame restarts the counters
	task automatic test_restart();
		set_frame(6, 4);
		for (int i = 0; i < 9; i++) send_random_pixel();
		set_frame(6, 4);
		send_frame();
	endtask

	task automatic test_random(int unsigned frames);
		for (int unsigned f = 0; f < frames; f++) begin
			if ($urandom_range(0, 9) == 0)
				set_weights($urandom_range(0, 511), $urandom_range(0, 511),
					$urandom_range(0, 511));
			else
				set_weights($urandom_range(0, 256), $urandom_range(0, 256),
					$urandom_range(0, 256));
			set_frame($urandom_range(1, 9), $urandom_range(1, 6));
			send_frame();
		end
	endtask

	// long receiver hold-off so the block stalls its input
	task automatic test_backpressure();
		set_frame(5, 3);
		hold_recv = 1'b1;
		send_frame();
		drain();
	endtask

	// part of a row at the largest width, then at two rows
	task automatic test_wide();
		set_frame(1024, 1);
		for (int i = 0; i < 40; i++) send_random_pixel();
		set_frame(MaxW, 2);
		for (int i = 0; i < 3; i++) send_random_pixel();
	endtask

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !hold_recv && (($urandom % 100) >= recv_idle_pct);
		end
	end

	initial begin
		hold_recv = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_recv) begin
				repeat (600) @(posedge clk);
				hold_recv = 1'b0;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			edge_res_t got, want;
			got = {m_tdata[7:0], m_tdata[15:8], m_tdata[25:16], m_tdata[37:26], m_tlast};
			results_seen++;
			if (edge_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", got);
			end else begin
				want = edge_queue.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected mag %0d a %0d x %0d y %0d last %0d",
							want.magnitude, want.opacity_out, want.column, want.line,
							want.last_of_run);
						$display("          got      mag %0d a %0d x %0d y %0d last %0d",
							got.magnitude, got.opacity_out, got.column, got.line,
							got.last_of_run);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || done_flag)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		s_tvalid = 0; s_tdata = '0;
		idle_cycles = 0; done_flag = 0;
		mismatches = 0; results_seen = 0; pixels_sent = 0;
		cfg_w = 640; cfg_h = 480; wt_r = 77; wt_g = 150; wt_b = 29;
		for (int i = 0; i < MaxW; i++) begin
			older_row[i] = 0; newer_row[i] = 0; alpha_line[i] = 0;
		end
		win = '{default: '0};
		awin = '{default: '0};
		col_pos = 0; row_pos = 0;
		send_idle_pct = 9; recv_idle_pct = 62;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_restart();
		test_random(4);
		test_backpressure();
		send_idle_pct = 62; recv_idle_pct = 9;
		test_random(4);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(4);
		test_wide();
		drain();
		repeat (50) @(posedge clk);
		done_flag = 1;
		$display("sent %0d pixels over several geometries and weights, checked %0d results",
			pixels_sent, results_seen);
		if (mismatches == 0 && edge_queue.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, edge_queue.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
